FILE: rtl/pipm_pkg.sv
// ----------------------------------------------------------------------------
// pipm_pkg
// Shared types and constants of the pulse interval power meter.
// ----------------------------------------------------------------------------
package pipm_pkg;

    localparam int STAMP_W           = 32;
    localparam int POWER_W           = 22;
    localparam int MIN_HIGH_W        = 16;
    localparam int MIN_INTERVAL_W    = 22;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 22;
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [MIN_HIGH_W-1:0]     MIN_HIGH_RESET     = 16'd50;
    localparam logic [MIN_INTERVAL_W-1:0] MIN_INTERVAL_RESET = 22'd600;
    localparam logic [POWER_W-1:0]        ENERGY_SCALE_RESET = 22'd3600000;

    localparam logic OP_RISE = 1'b0;
    localparam logic OP_FALL = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_HIGH     = 2'd0,
        CFG_MIN_INTERVAL = 2'd1,
        CFG_ENERGY_SCALE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

FILE: rtl/pipm_front.sv
// ----------------------------------------------------------------------------
// pipm_front
// Edge classifier: holds configuration and pulse timing state, filters
// short pulses and too-close pulses, and queues intervals to be divided.
// ----------------------------------------------------------------------------
module pipm_front #(
    parameter int TIME_BITS = pipm_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              op,
    input  logic [pipm_pkg::STAMP_W-1:0]      stamp_ms,
    output logic                              full,
    input  logic                              wr_en,
    input  logic [pipm_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [pipm_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [TIME_BITS-1:0]              q_interval,
    output logic [pipm_pkg::POWER_W-1:0]      q_scale
);

    localparam int CMP_W = (TIME_BITS > pipm_pkg::MIN_INTERVAL_W) ?
                           TIME_BITS : pipm_pkg::MIN_INTERVAL_W;

    logic [pipm_pkg::MIN_HIGH_W-1:0]     min_high_reg, min_high_next;
    logic [pipm_pkg::MIN_INTERVAL_W-1:0] min_interval_reg, min_interval_next;
    logic [pipm_pkg::POWER_W-1:0]        scale_reg, scale_next;
    logic [TIME_BITS-1:0]                rise_time_reg, rise_time_next;
    logic [TIME_BITS-1:0]                prev_time_reg, prev_time_next;
    logic                                have_first_reg, have_first_next;

    logic                 accept;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] high_time;
    logic [TIME_BITS-1:0] interval;
    logic                 high_ok;
    logic                 gap_ok;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign now        = TIME_BITS'(stamp_ms);
    assign high_time  = now - rise_time_reg;
    assign interval   = now - prev_time_reg;
    assign high_ok    = high_time >= TIME_BITS'(min_high_reg);
    assign gap_ok     = CMP_W'(interval) >= CMP_W'(min_interval_reg);
    assign q_interval = interval;
    assign q_scale    = scale_reg;

    always_comb
    begin
        min_high_next     = min_high_reg;
        min_interval_next = min_interval_reg;
        scale_next        = scale_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                pipm_pkg::CFG_MIN_HIGH:
                    min_high_next = pipm_pkg::MIN_HIGH_W'(wr_data);
                pipm_pkg::CFG_MIN_INTERVAL:
                    min_interval_next = pipm_pkg::MIN_INTERVAL_W'(wr_data);
                pipm_pkg::CFG_ENERGY_SCALE:
                    scale_next = pipm_pkg::POWER_W'(wr_data);
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        rise_time_next  = rise_time_reg;
        prev_time_next  = prev_time_reg;
        have_first_next = have_first_reg;
        q_push          = 1'b0;
        if (accept)
        begin
            if (op == pipm_pkg::OP_RISE)
            begin
                rise_time_next = now;
            end
            else if (high_ok)
            begin
                if (!have_first_reg)
                begin
                    have_first_next = 1'b1;
                    prev_time_next  = now;
                end
                else if (gap_ok)
                begin
                    q_push         = 1'b1;
                    prev_time_next = now;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_high_reg     <= pipm_pkg::MIN_HIGH_RESET;
            min_interval_reg <= pipm_pkg::MIN_INTERVAL_RESET;
            scale_reg        <= pipm_pkg::ENERGY_SCALE_RESET;
            rise_time_reg    <= '0;
            prev_time_reg    <= '0;
            have_first_reg   <= 1'b0;
        end
        else
        begin
            min_high_reg     <= min_high_next;
            min_interval_reg <= min_interval_next;
            scale_reg        <= scale_next;
            rise_time_reg    <= rise_time_next;
            prev_time_reg    <= prev_time_next;
            have_first_reg   <= have_first_next;
        end
    end

endmodule

FILE: rtl/pipm_queue.sv
// ----------------------------------------------------------------------------
// pipm_queue
// Small register FIFO decoupling the classifier from the divider.
// ----------------------------------------------------------------------------
module pipm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pipm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/pipm_back.sv
// ----------------------------------------------------------------------------
// pipm_back
// Restoring divider, one quotient bit per cycle, with a result register.
// ----------------------------------------------------------------------------
module pipm_back #(
    parameter int TIME_BITS = pipm_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_empty,
    input  logic [TIME_BITS+pipm_pkg::POWER_W-1:0]    q_data,
    output logic                                      q_pop,
    output logic                                      empty,
    input  logic                                      pop,
    output logic [pipm_pkg::POWER_W-1:0]              power_watts
);

    localparam int QW    = pipm_pkg::POWER_W;
    localparam int CNT_W = $clog2(QW);

    pipm_pkg::back_state_t state_reg, state_next;

    logic [TIME_BITS-1:0] div_reg, div_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [QW-1:0]        out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [TIME_BITS-1:0] q_interval;
    logic [QW-1:0]        q_scale;
    logic [TIME_BITS:0]   rem_sh;
    logic [TIME_BITS:0]   rem_sub;
    logic                 ge;
    logic                 load_out;

    assign q_interval  = q_data[TIME_BITS+QW-1:QW];
    assign q_scale     = q_data[QW-1:0];
    assign rem_sh      = {rem_reg, quo_reg[QW-1]};
    assign rem_sub     = rem_sh - {1'b0, div_reg};
    assign ge          = rem_sh >= {1'b0, div_reg};
    assign empty       = !out_valid_reg;
    assign power_watts = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pipm_pkg::ST_IDLE:
                if (!q_empty)
                begin
                    state_next = (q_interval == '0) ? pipm_pkg::ST_DONE : pipm_pkg::ST_DIV;
                end
            pipm_pkg::ST_DIV:
                if (cnt_reg == '0)
                begin
                    state_next = pipm_pkg::ST_DONE;
                end
            pipm_pkg::ST_DONE:
                if (!out_valid_reg || pop)
                begin
                    state_next = pipm_pkg::ST_IDLE;
                end
            default:
                state_next = pipm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            pipm_pkg::ST_IDLE: q_pop    = !q_empty;
            pipm_pkg::ST_DIV:  ;
            pipm_pkg::ST_DONE: load_out = !out_valid_reg || pop;
            default:           ;
        endcase
    end

    always_comb
    begin
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            // zero interval skips division; quotient register then holds the scale
            div_next = q_interval;
            rem_next = '0;
            quo_next = q_scale;
            cnt_next = CNT_W'(QW - 1);
        end
        if (state_reg == pipm_pkg::ST_DIV)
        begin
            rem_next = ge ? TIME_BITS'(rem_sub) : TIME_BITS'(rem_sh);
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_next       = quo_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pipm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

endmodule

FILE: rtl/pulse_interval_power_meter_unit.sv
// ----------------------------------------------------------------------------
// pulse_interval_power_meter_unit
// Energy meter pulse edges in, power readings out.
// ----------------------------------------------------------------------------
// Edge requests are classified in the cycle they are accepted; every edge is
// accepted at once while the two-entry interval queue has room. The restoring
// divider pops each counted pulse, forms its 22 quotient bits at one bit per
// cycle and loads the result register; a zero interval skips the division.
// Results wait in the result register until popped; the divider then holds its
// next quotient and the classifier goes on while the queue has room.
module pulse_interval_power_meter_unit #(
    parameter int TIME_BITS = pipm_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              op,
    input  logic [pipm_pkg::STAMP_W-1:0]      stamp_ms,
    output logic                              empty,
    input  logic                              pop,
    output logic [pipm_pkg::POWER_W-1:0]      power_watts,
    input  logic                              wr_en,
    input  logic [pipm_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [pipm_pkg::CFG_DATA_W-1:0]   wr_data
);

    localparam int QW_ENTRY = TIME_BITS + pipm_pkg::POWER_W;

    logic                         q_full;
    logic                         q_push;
    logic [TIME_BITS-1:0]         q_interval;
    logic [pipm_pkg::POWER_W-1:0] q_scale;
    logic                         q_pop;
    logic                         q_empty;
    logic [QW_ENTRY-1:0]          q_rd_data;

    pipm_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .op         (op),
        .stamp_ms   (stamp_ms),
        .full       (full),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_interval (q_interval),
        .q_scale    (q_scale)
    );

    pipm_queue #(
        .WIDTH (QW_ENTRY),
        .DEPTH (pipm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data ({q_interval, q_scale}),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    pipm_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .power_watts (power_watts)
    );

endmodule

FILE: rtl/pipm_checker.sv
// ----------------------------------------------------------------------------
// pipm_checker
// Port-level checks of the power meter, bound to the top level.
// ----------------------------------------------------------------------------
module pipm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              full,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [pipm_pkg::POWER_W-1:0]      power_watts,
    input  logic                              wr_en,
    input  logic [pipm_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [pipm_pkg::CFG_DATA_W-1:0]   wr_data
);

    logic [pipm_pkg::POWER_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= pipm_pkg::ENERGY_SCALE_RESET;
        end
        else if (wr_en && (wr_index == pipm_pkg::CFG_ENERGY_SCALE))
        begin
            scale_reg <= pipm_pkg::POWER_W'(wr_data);
        end
    end

    // power never exceeds the scale: the interval is at least one, or zero yields the scale itself
    a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> power_watts <= scale_reg)
        else $error("power reading above energy scale");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(power_watts)))
        else $error("waiting result changed or vanished");

    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind pulse_interval_power_meter_unit pipm_checker u_pipm_checker (.*);

FILE: bench/pulse_interval_power_meter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_power_meter_unit_test
// Self-checking bench for the pulse interval power meter. Edge requests are
// fed from a backlog by a clocked driver. A tracker of rise time, last pulse
// time and configuration predicts every power reading. A clocked monitor
// checks the readings in order. Phases cover directed corner edges, then
// random pulse trains under extreme and random register settings, with
// random stalls on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module pulse_interval_power_meter_unit_test;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 64;
    localparam int PHASES      = 10;
    localparam int PHASE_EDGES = 165;
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        logic                         kind;
        logic [pipm_pkg::STAMP_W-1:0] stamp;
    } edge_req_t;

    logic                             clk;
    logic                             rst_n;
    logic                             push = 1'b0;
    logic                             full;
    logic                             op = pipm_pkg::OP_RISE;
    logic [pipm_pkg::STAMP_W-1:0]     stamp_ms = '0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic [pipm_pkg::POWER_W-1:0]     power_watts;
    logic                             wr_en;
    logic [pipm_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [pipm_pkg::CFG_DATA_W-1:0]  wr_data;

    edge_req_t                    edge_backlog[$];
    logic [pipm_pkg::POWER_W-1:0] power_due[$];

    // tracked meter state and settings
    logic [pipm_pkg::STAMP_W-1:0]        rise_at = '0;
    logic [pipm_pkg::STAMP_W-1:0]        last_pulse_at = '0;
    logic                                pulse_armed = 1'b0;
    logic [pipm_pkg::MIN_HIGH_W-1:0]     min_high;
    logic [pipm_pkg::MIN_INTERVAL_W-1:0] min_gap;
    logic [pipm_pkg::POWER_W-1:0]        scale;

    logic [pipm_pkg::STAMP_W-1:0] clock_ms;
    logic                         req_taken = 1'b0;
    logic                         res_taken = 1'b0;
    logic                         send_lazy;
    logic                         rcv_lazy;
    int unsigned                  send_gap = 0;
    int unsigned                  rcv_stall = 0;
    int unsigned                  hold_left = 0;
    int                           holds_asked;
    int                           holds_done = 0;
    int                           fail_count = 0;
    int                           cycle_count = 0;

    pulse_interval_power_meter_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .stamp_ms    (stamp_ms),
        .empty       (empty),
        .pop         (pop),
        .power_watts (power_watts),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic void meter_edge(input logic kind,
                                       input logic [pipm_pkg::STAMP_W-1:0] now);
        logic [pipm_pkg::STAMP_W-1:0] high_len;
        logic [pipm_pkg::STAMP_W-1:0] interval;
        logic [pipm_pkg::POWER_W-1:0] watts;
        high_len = now - rise_at;
        interval = now - last_pulse_at;
        if (kind == pipm_pkg::OP_RISE)
        begin
            rise_at = now;
        end
        else if (high_len < {16'd0, min_high})
        begin
        end
        else if (!pulse_armed)
        begin
            pulse_armed   = 1'b1;
            last_pulse_at = now;
        end
        else if (interval >= {10'd0, min_gap})
        begin
            if (interval == '0)
                watts = scale;
            else
                watts = pipm_pkg::POWER_W'({10'd0, scale} / interval);
            power_due.push_back(watts);
            last_pulse_at = now;
        end
    endfunction

    function automatic void add_edge(input logic kind,
                                     input logic [pipm_pkg::STAMP_W-1:0] stamp);
        edge_req_t e;
        e.kind  = kind;
        e.stamp = stamp;
        edge_backlog.push_back(e);
    endfunction

    task automatic add_pulse(input logic [pipm_pkg::STAMP_W-1:0] high_len,
                             input logic [pipm_pkg::STAMP_W-1:0] spacing);
        add_edge(pipm_pkg::OP_RISE, clock_ms);
        add_edge(pipm_pkg::OP_FALL, clock_ms + high_len);
        clock_ms = clock_ms + spacing;
    endtask

    task automatic write_reg(input pipm_pkg::cfg_index_t idx,
                             input logic [pipm_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        case (idx)
            pipm_pkg::CFG_MIN_HIGH:     min_high = value[pipm_pkg::MIN_HIGH_W-1:0];
            pipm_pkg::CFG_MIN_INTERVAL: min_gap  = value[pipm_pkg::MIN_INTERVAL_W-1:0];
            pipm_pkg::CFG_ENERGY_SCALE: scale    = value[pipm_pkg::POWER_W-1:0];
            default:                    ;
        endcase
    endtask

    task automatic set_meter(input logic [pipm_pkg::MIN_HIGH_W-1:0] high_ms,
                             input logic [pipm_pkg::MIN_INTERVAL_W-1:0] gap_ms,
                             input logic [pipm_pkg::POWER_W-1:0] dividend);
        write_reg(pipm_pkg::CFG_MIN_HIGH, {6'd0, high_ms});
        write_reg(pipm_pkg::CFG_MIN_INTERVAL, gap_ms);
        write_reg(pipm_pkg::CFG_ENERGY_SCALE, dividend);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain;
        while (edge_backlog.size() != 0 || push || power_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        edge_req_t nxt;
        if (rst_n)
        begin
            if (push && !req_taken)
            begin
            end
            else if (send_gap > 0)
            begin
                push     <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (edge_backlog.size() != 0)
            begin
                nxt      = edge_backlog.pop_front();
                push     <= 1'b1;
                op       <= nxt.kind;
                stamp_ms <= nxt.stamp;
                send_gap = send_lazy ? $urandom_range(0, 12) : 0;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // result consumer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
                rcv_stall = rcv_lazy ? $urandom_range(0, 12) : 0;
            if (holds_asked != holds_done)
            begin
                hold_left  = HOLD_CYCLES;
                holds_done = holds_done + 1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pop       <= 1'b0;
            end
            else if (rcv_stall > 0)
            begin
                rcv_stall = rcv_stall - 1;
                pop       <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        logic [pipm_pkg::POWER_W-1:0] want;
        if (rst_n)
        begin
            req_taken = push && !full;
            res_taken = pop && !empty;
            if (res_taken)
            begin
                if (power_due.size() == 0)
                begin
                    $error("power_watts: no reading expected, actual %0d", power_watts);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = power_due.pop_front();
                    if (power_watts !== want)
                    begin
                        $error("power_watts: expected %0d, actual %0d", want, power_watts);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (req_taken)
                meter_edge(op, stamp_ms);
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int                           ph;
        int                           n;
        int                           choice;
        logic [pipm_pkg::STAMP_W-1:0] high_len;
        logic [pipm_pkg::STAMP_W-1:0] spacing;

        rst_n       = 1'b0;
        wr_en       = 1'b0;
        wr_index    = pipm_pkg::CFG_MIN_HIGH;
        wr_data     = '0;
        send_lazy   = 1'b1;
        rcv_lazy    = 1'b1;
        holds_asked = 0;
        min_high    = pipm_pkg::MIN_HIGH_RESET;
        min_gap     = pipm_pkg::MIN_INTERVAL_RESET;
        scale       = pipm_pkg::ENERGY_SCALE_RESET;
        clock_ms    = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: fall before any rise, short pulse, too soon, wrap
        add_edge(pipm_pkg::OP_FALL, 32'd30);
        add_edge(pipm_pkg::OP_FALL, 32'd100);
        add_edge(pipm_pkg::OP_RISE, 32'd200);
        add_edge(pipm_pkg::OP_FALL, 32'd230);
        add_edge(pipm_pkg::OP_RISE, 32'd300);
        add_edge(pipm_pkg::OP_FALL, 32'd400);
        add_edge(pipm_pkg::OP_RISE, 32'd1000);
        add_edge(pipm_pkg::OP_FALL, 32'd1100);
        add_edge(pipm_pkg::OP_RISE, 32'hFFFF_FF00);
        add_edge(pipm_pkg::OP_FALL, 32'hFFFF_FFFF);
        add_edge(pipm_pkg::OP_RISE, 32'h0000_0010);
        add_edge(pipm_pkg::OP_FALL, 32'h0000_0300);
        drain();

        // zero interval, unit interval, high time across the wrap
        set_meter(16'd0, 22'd0, 22'h3F_FFFF);
        add_edge(pipm_pkg::OP_FALL, 32'h0000_0300);
        add_edge(pipm_pkg::OP_RISE, 32'd5);
        add_edge(pipm_pkg::OP_FALL, 32'd5);
        add_edge(pipm_pkg::OP_FALL, 32'd6);
        add_edge(pipm_pkg::OP_RISE, 32'hFFFF_FFFF);
        add_edge(pipm_pkg::OP_FALL, 32'd0);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_meter(16'd0, 22'd0, 22'd1);
                1:       set_meter(16'hFFFF, 22'h3F_FFFF, 22'h3F_FFFF);
                2:       set_meter(pipm_pkg::MIN_HIGH_RESET, pipm_pkg::MIN_INTERVAL_RESET,
                                   pipm_pkg::ENERGY_SCALE_RESET);
                default: set_meter(16'($urandom_range(0, 3000)),
                                   22'($urandom_range(0, 20000)),
                                   22'($urandom_range(1, 22'h3F_FFFF)));
            endcase
            send_lazy = (ph != 3) && (ph != 5) && ($urandom_range(0, 3) != 0);
            rcv_lazy  = (ph != 5) && ($urandom_range(0, 3) != 0);
            if (ph == 3)
                holds_asked = holds_asked + 1;
            clock_ms = $urandom();
            n = 0;
            while (n < PHASE_EDGES)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 75)
                begin
                    if ($urandom_range(0, 6) == 0)
                        high_len = $urandom_range(0, min_high);
                    else
                        high_len = min_high + $urandom_range(0, 200);
                    case ($urandom_range(0, 5))
                        0:       spacing = $urandom_range(0, min_gap);
                        1:       spacing = $urandom();
                        default: spacing = min_gap + ($urandom() >> $urandom_range(10, 31));
                    endcase
                    add_pulse(high_len, spacing);
                    n = n + 2;
                end
                else if (choice < 90)
                begin
                    add_edge(1'($urandom_range(0, 1)), clock_ms + $urandom_range(0, 300));
                    n = n + 1;
                end
                else
                begin
                    add_edge(1'($urandom_range(0, 1)), $urandom());
                    n = n + 1;
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pipm_pkg.sv
rtl/pipm_front.sv
rtl/pipm_queue.sv
rtl/pipm_back.sv
rtl/pulse_interval_power_meter_unit.sv
rtl/pipm_checker.sv
bench/pulse_interval_power_meter_unit_test.sv
